[src/wall_follow_drive_controller_core_macros.svh]
// Assertion helpers used by the controller RTL; they expect i_clk and i_rst_n in scope.
`ifndef WALL_FOLLOW_DRIVE_CONTROLLER_CORE_MACROS_SVH
`define WALL_FOLLOW_DRIVE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define WFDC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WFDC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/wfdc_pkg.sv]
`timescale 1ns / 1ps
package wfdc_pkg;

    localparam int DIST_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 16;
    localparam int MS_W       = 16;
    localparam int DUTY_W     = 16;
    localparam int LVL_W      = 16;

    localparam logic [DUTY_W-1:0] DUTY_CAP = 16'd52429;

    localparam logic [GAIN_W-1:0] KP_RST = 16'd3277;
    localparam logic [GAIN_W-1:0] KD_RST = 16'd7864;
    localparam int WALL_GOAL_RST   = 10;
    localparam int WALL_NEAR_RST   = 22;
    localparam int FRONT_STOP_RST  = 25;
    localparam int FRONT_SLOW_RST  = 80;
    localparam int ESTOP_RST       = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACK_RIGHT  = 3'd0,
        CFG_KP_GAIN      = 3'd1,
        CFG_KD_GAIN      = 3'd2,
        CFG_WALL_GOAL    = 3'd3,
        CFG_WALL_NEAR    = 3'd4,
        CFG_FRONT_STOP   = 3'd5,
        CFG_FRONT_SLOW   = 3'd6,
        CFG_ESTOP        = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } t_sign;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_KP,
        ST_MUL_MS,
        ST_MUL_KD,
        ST_MUL_K1000,
        ST_PD_SUM,
        ST_PD_LOAD,
        ST_PD_DIV,
        ST_PD_SAVE,
        ST_SQ_NUM,
        ST_SQ_DEN,
        ST_TH_LOAD,
        ST_TH_DIV,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        MUL_KP_E,
        MUL_P1_MS,
        MUL_KD_DE,
        MUL_P2_K,
        MUL_SQ_NUM,
        MUL_SQ_DEN
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     pd_sum;
        logic     div_load_pd;
        logic     div_load_th;
        logic     div_step;
        logic     pd_save;
        logic     update;
        logic     emit;
    } t_cmd;

endpackage

[src/wfdc_if.sv]
`timescale 1ns / 1ps
interface wfdc_in_if #(
    parameter int DIST_BITS = 10
);
    logic                 valid;
    logic                 ready;
    logic [DIST_BITS-1:0] left_cm;
    logic [DIST_BITS-1:0] front_cm;
    logic [DIST_BITS-1:0] right_cm;
    logic [2:0]           valid_bits;
    logic [15:0]          elapsed_ms;

    modport source (output valid, left_cm, front_cm, right_cm, valid_bits, elapsed_ms,
                    input ready);
    modport sink (input valid, left_cm, front_cm, right_cm, valid_bits, elapsed_ms,
                  output ready);
endinterface

interface wfdc_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        right_duty;
    logic [15:0]        left_duty;
    logic               dir_switch;
    logic [1:0]         right_dir;
    logic [1:0]         left_dir;
    logic signed [15:0] steer_level;
    logic signed [15:0] throttle_level;

    modport source (output valid, right_duty, left_duty, dir_switch, right_dir, left_dir,
                    steer_level, throttle_level, input ready);
    modport sink (input valid, right_duty, left_duty, dir_switch, right_dir, left_dir,
                  steer_level, throttle_level, output ready);
endinterface

[src/wall_follow_drive_controller_core.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload
// i_in      in   left_cm, front_cm, right_cm, valid_bits, elapsed_ms
// o_out     out  right_duty, left_duty, dir_switch, right_dir, left_dir,
//                steer_level, throttle_level
// i_cfg_*   in   write enable, register index, write data
//
// Each item runs four PD multiplies, a division, two square multiplies and a second
// division, sharing one multiplier; the restoring divider yields one bit per cycle.
// A new item is taken only in idle; a finished result waits in the output register.
// A stalled output holds the controller before it returns to idle.
// Synchronous active-low reset clears the ramp states, last error and wheel signs.
module wall_follow_drive_controller_core #(
    parameter int DIST_BITS = wfdc_pkg::DIST_BITS_DEF,
    parameter int FRAC_BITS = wfdc_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    wfdc_in_if.sink                         i_in,
    wfdc_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [wfdc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wfdc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wfdc_pkg::*;

    logic                r_track_right;
    logic [GAIN_W-1:0]   r_kp_gain, r_kd_gain;
    logic [DIST_BITS-1:0] r_wall_goal, r_wall_near, r_front_stop, r_front_slow, r_estop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_right  <= 1'b1;
            r_kp_gain      <= KP_RST;
            r_kd_gain      <= KD_RST;
            r_wall_goal    <= DIST_BITS'(WALL_GOAL_RST);
            r_wall_near    <= DIST_BITS'(WALL_NEAR_RST);
            r_front_stop   <= DIST_BITS'(FRONT_STOP_RST);
            r_front_slow   <= DIST_BITS'(FRONT_SLOW_RST);
            r_estop        <= DIST_BITS'(ESTOP_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TRACK_RIGHT:  r_track_right  <= i_cfg_data[0];
                CFG_KP_GAIN:      r_kp_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_KD_GAIN:      r_kd_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_WALL_GOAL:    r_wall_goal    <= i_cfg_data[DIST_BITS-1:0];
                CFG_WALL_NEAR:    r_wall_near    <= i_cfg_data[DIST_BITS-1:0];
                CFG_FRONT_STOP:   r_front_stop   <= i_cfg_data[DIST_BITS-1:0];
                CFG_FRONT_SLOW:   r_front_slow   <= i_cfg_data[DIST_BITS-1:0];
                CFG_ESTOP:        r_estop        <= i_cfg_data[DIST_BITS-1:0];
                default: ;
            endcase
        end
    end

    t_cmd cmd;
    logic in_ready, out_valid;

    wfdc_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    wfdc_datapath #(
        .DIST_BITS(DIST_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_left_cm        (i_in.left_cm),
        .i_front_cm       (i_in.front_cm),
        .i_right_cm       (i_in.right_cm),
        .i_valid_bits     (i_in.valid_bits),
        .i_elapsed_ms     (i_in.elapsed_ms),
        .i_track_right    (r_track_right),
        .i_kp_gain        (r_kp_gain),
        .i_kd_gain        (r_kd_gain),
        .i_wall_goal_cm   (r_wall_goal),
        .i_wall_near_cm   (r_wall_near),
        .i_front_stop_cm  (r_front_stop),
        .i_front_slow_cm  (r_front_slow),
        .i_estop_cm       (r_estop),
        .o_right_duty     (o_out.right_duty),
        .o_left_duty      (o_out.left_duty),
        .o_dir_switch     (o_out.dir_switch),
        .o_right_dir      (o_out.right_dir),
        .o_left_dir       (o_out.left_dir),
        .o_steer_level    (o_out.steer_level),
        .o_throttle_level (o_out.throttle_level)
    );
endmodule

[src/wfdc_ctrl.sv]
`timescale 1ns / 1ps
module wfdc_ctrl #(
    parameter int FRAC_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output wfdc_pkg::t_cmd o_cmd
);
    import wfdc_pkg::*;
    `include "wall_follow_drive_controller_core_macros.svh"

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_vld, n_out_vld;
    logic out_free, in_div;

    assign out_free = !r_out_vld || i_out_ready;
    assign in_div   = (r_state == ST_PD_DIV) || (r_state == ST_TH_DIV);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_MUL_KP;
            ST_MUL_KP:    n_state = ST_MUL_MS;
            ST_MUL_MS:    n_state = ST_MUL_KD;
            ST_MUL_KD:    n_state = ST_MUL_K1000;
            ST_MUL_K1000: n_state = ST_PD_SUM;
            ST_PD_SUM:    n_state = ST_PD_LOAD;
            ST_PD_LOAD:   n_state = ST_PD_DIV;
            ST_PD_DIV:    if (r_cnt == CNT_LAST) n_state = ST_PD_SAVE;
            ST_PD_SAVE:   n_state = ST_SQ_NUM;
            ST_SQ_NUM:    n_state = ST_SQ_DEN;
            ST_SQ_DEN:    n_state = ST_TH_LOAD;
            ST_TH_LOAD:   n_state = ST_TH_DIV;
            ST_TH_DIV:    if (r_cnt == CNT_LAST) n_state = ST_UPDATE;
            ST_UPDATE:    n_state = ST_EMIT;
            ST_EMIT:      if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_KP_E;
        o_in_ready    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL_KP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_KP_E;
            end
            ST_MUL_MS: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P1_MS;
            end
            ST_MUL_KD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_KD_DE;
            end
            ST_MUL_K1000: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P2_K;
            end
            ST_PD_SUM:  o_cmd.pd_sum = 1'b1;
            ST_PD_LOAD: o_cmd.div_load_pd = 1'b1;
            ST_PD_DIV:  o_cmd.div_step = 1'b1;
            ST_PD_SAVE: o_cmd.pd_save = 1'b1;
            ST_SQ_NUM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SQ_NUM;
            end
            ST_SQ_DEN: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SQ_DEN;
            end
            ST_TH_LOAD: o_cmd.div_load_th = 1'b1;
            ST_TH_DIV:  o_cmd.div_step = 1'b1;
            ST_UPDATE:  o_cmd.update = 1'b1;
            ST_EMIT:    o_cmd.emit = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_cnt = '0;
        if (in_div && r_cnt != CNT_LAST) n_cnt = r_cnt + 1'b1;
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.emit) n_out_vld = 1'b1;
        else if (i_out_ready) n_out_vld = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

    `WFDC_ASSERT_NXT(a_accept_starts, o_in_ready && i_in_valid, r_state == ST_MUL_KP,
        "accepted item did not start the multiply sequence")
    `WFDC_ASSERT_NXT(a_result_held, r_out_vld && !i_out_ready, r_out_vld,
        "pending result dropped while stalled")
    `WFDC_ASSERT_IMP(a_cnt_range, in_div, r_cnt <= CNT_LAST,
        "divider step count out of range")
    `WFDC_ASSERT_IMP(a_cnt_idle, !in_div, r_cnt == '0,
        "divider step count not cleared outside division")
endmodule

[src/wfdc_datapath.sv]
`timescale 1ns / 1ps
module wfdc_datapath #(
    parameter int DIST_BITS = 10,
    parameter int FRAC_BITS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wfdc_pkg::t_cmd                 i_cmd,
    input  logic [DIST_BITS-1:0]           i_left_cm,
    input  logic [DIST_BITS-1:0]           i_front_cm,
    input  logic [DIST_BITS-1:0]           i_right_cm,
    input  logic [2:0]                     i_valid_bits,
    input  logic [wfdc_pkg::MS_W-1:0]      i_elapsed_ms,
    input  logic                           i_track_right,
    input  logic [wfdc_pkg::GAIN_W-1:0]    i_kp_gain,
    input  logic [wfdc_pkg::GAIN_W-1:0]    i_kd_gain,
    input  logic [DIST_BITS-1:0]           i_wall_goal_cm,
    input  logic [DIST_BITS-1:0]           i_wall_near_cm,
    input  logic [DIST_BITS-1:0]           i_front_stop_cm,
    input  logic [DIST_BITS-1:0]           i_front_slow_cm,
    input  logic [DIST_BITS-1:0]           i_estop_cm,
    output logic [wfdc_pkg::DUTY_W-1:0]    o_right_duty,
    output logic [wfdc_pkg::DUTY_W-1:0]    o_left_duty,
    output logic                           o_dir_switch,
    output logic [1:0]                     o_right_dir,
    output logic [1:0]                     o_left_dir,
    output logic signed [wfdc_pkg::LVL_W-1:0] o_steer_level,
    output logic signed [wfdc_pkg::LVL_W-1:0] o_throttle_level
);
    import wfdc_pkg::*;

    localparam int DW  = DIST_BITS;
    localparam int EW  = DW + 1;
    localparam int DEW = DW + 2;
    localparam int MA  = DW + 19;
    localparam int MB  = GAIN_W + 2;
    localparam int PW  = MA + MB;
    localparam int NW  = PW + 1;
    localparam int DVW = (2 * DW > MS_W + 16) ? 2 * DW : MS_W + 16;
    localparam int RW  = DVW + 1;
    localparam int QW  = FRAC_BITS;
    localparam int LW  = FRAC_BITS + 4;
    localparam int AW  = LW + 16;

    localparam logic signed [LW-1:0] ONE_Q  = LW'(longint'(1) <<< FRAC_BITS);
    localparam logic signed [LW-1:0] DEAD_Q = LW'(((longint'(5) <<< FRAC_BITS) + 50) / 100);
    localparam logic signed [LW-1:0] SSLEW_Q = LW'(((longint'(12) <<< FRAC_BITS) + 50) / 100);
    localparam logic signed [LW-1:0] TSLEW_Q = LW'(((longint'(6) <<< FRAC_BITS) + 50) / 100);
    localparam logic signed [LW-1:0] TCAP_Q = LW'(((longint'(35) <<< FRAC_BITS) + 50) / 100);
    localparam logic signed [LW-1:0] BIAS_Q = LW'(((longint'(80) <<< FRAC_BITS) + 50) / 100);

    function automatic logic signed [LW-1:0] clamp_sym(input logic signed [LW-1:0] v,
                                                       input logic signed [LW-1:0] lim);
        logic signed [LW-1:0] res;
        res = v;
        if (v > lim) res = lim;
        else if (v < -lim) res = -lim;
        return res;
    endfunction

    // latched item
    logic [DW-1:0]   r_left, r_front, r_right;
    logic [2:0]      r_vb;
    logic [MS_W-1:0] r_ms;

    // state
    logic signed [LW-1:0] r_steer, r_thr, n_steer, n_thr;
    logic signed [EW-1:0] r_prev;
    t_sign                r_rsign, r_lsign;

    // work registers
    logic signed [MA-1:0] r_p1, r_p2;
    logic signed [PW-1:0] r_t1, r_t2;
    logic [DVW-1:0]       r_sqn, r_sqd, r_dvs;
    logic signed [NW-1:0] r_num;
    logic [RW-1:0]        r_rem;
    logic [QW-1:0]        r_quo;
    logic                 r_pd_neg, r_pd_sat;
    logic signed [LW-1:0] r_sref;

    // output payload
    logic [DUTY_W-1:0]       r_o_rduty, r_o_lduty;
    logic                    r_o_sw;
    logic [1:0]              r_o_rdir, r_o_ldir;
    logic signed [LVL_W-1:0] r_o_steer, r_o_thr;

    // followed side
    logic          sv, close;
    logic [DW-1:0] scm;
    logic signed [EW-1:0]  w_e;
    logic signed [DEW-1:0] w_de;
    logic                  ms_gt1;

    assign sv     = i_track_right ? r_vb[2] : r_vb[0];
    assign scm    = i_track_right ? r_right : r_left;
    assign close  = (scm != '0) && (scm < i_wall_near_cm);
    assign w_e    = {1'b0, scm} - {1'b0, i_wall_goal_cm};
    assign w_de   = DEW'(w_e) - DEW'(r_prev);
    assign ms_gt1 = r_ms > MS_W'(1);

    // shared multiplier
    logic [DW-1:0] th_num, th_den;
    logic signed [MA-1:0] m_a;
    logic signed [MB-1:0] m_b;
    logic signed [PW-1:0] m_p;

    assign th_num = r_front - i_front_stop_cm;
    assign th_den = i_front_slow_cm - i_front_stop_cm;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_KP_E: begin
                m_a = MA'(w_e);
                m_b = MB'({1'b0, i_kp_gain});
            end
            MUL_P1_MS: begin
                m_a = r_p1;
                m_b = MB'({1'b0, r_ms});
            end
            MUL_KD_DE: begin
                m_a = MA'(w_de);
                m_b = MB'({1'b0, i_kd_gain});
            end
            MUL_P2_K: begin
                m_a = r_p2;
                m_b = MB'(1000);
            end
            MUL_SQ_NUM: begin
                m_a = MA'({1'b0, th_num});
                m_b = MB'({1'b0, th_num});
            end
            MUL_SQ_DEN: begin
                m_a = MA'({1'b0, th_den});
                m_b = MB'({1'b0, th_den});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = m_a * m_b;

    // PD magnitude and divisor
    logic [NW-1:0]   w_mag;
    logic [MS_W-1:0] w_den;
    logic [DVW-1:0]  w_dlim;
    assign w_mag  = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
    assign w_den  = ms_gt1 ? r_ms : MS_W'(1);
    assign w_dlim = DVW'({w_den, 16'b0});

    // restoring divider step
    logic [RW-1:0] w_sh;
    logic          w_ge;
    assign w_sh = {r_rem[RW-2:0], 1'b0};
    assign w_ge = w_sh >= RW'(r_dvs);

    // steering reference
    logic signed [LW-1:0] w_res, w_pdv, w_bias;
    assign w_res  = r_pd_sat ? ONE_Q : LW'({1'b0, r_quo});
    assign w_pdv  = (r_pd_neg ^ i_track_right) ? -w_res : w_res;
    assign w_bias = close ? (i_track_right ? -BIAS_Q : BIAS_Q) : '0;

    // throttle reference and slew
    logic                 th_gate, th_full;
    logic signed [LW-1:0] w_tref, w_tcap;
    assign th_gate = r_vb[1] && (r_front > i_estop_cm) && (r_front > i_front_stop_cm);
    assign th_full = r_front >= i_front_slow_cm;
    assign w_tref  = !th_gate ? '0 : (th_full ? ONE_Q : LW'({1'b0, r_quo}));
    assign w_tcap  = (sv && close && w_tref > TCAP_Q) ? TCAP_Q : w_tref;
    assign n_steer = r_steer + clamp_sym(r_sref - r_steer, SSLEW_Q);
    assign n_thr   = r_thr + clamp_sym(w_tcap - r_thr, TSLEW_Q);

    // wheel mixing
    logic signed [LW-1:0] w_t, w_s, w_vr0, w_vl0, w_vr, w_vl, w_ar, w_al;
    logic [AW-1:0]        w_dr, w_dl;
    t_sign                w_sr, w_sl;
    logic                 w_sw;
    logic signed [31:0]   w_se, w_te;

    assign w_t   = clamp_sym(r_thr, ONE_Q);
    assign w_s   = clamp_sym(r_steer, ONE_Q);
    assign w_vr0 = clamp_sym(w_t + w_s, ONE_Q);
    assign w_vl0 = clamp_sym(w_t - w_s, ONE_Q);
    assign w_vr  = (w_vr0 > -DEAD_Q && w_vr0 < DEAD_Q) ? '0 : w_vr0;
    assign w_vl  = (w_vl0 > -DEAD_Q && w_vl0 < DEAD_Q) ? '0 : w_vl0;
    assign w_sr  = (w_vr > 0) ? SIGN_POS : ((w_vr < 0) ? SIGN_NEG : SIGN_ZERO);
    assign w_sl  = (w_vl > 0) ? SIGN_POS : ((w_vl < 0) ? SIGN_NEG : SIGN_ZERO);
    assign w_sw  = (w_sr != r_rsign) || (w_sl != r_lsign);
    assign w_ar  = w_vr[LW-1] ? -w_vr : w_vr;
    assign w_al  = w_vl[LW-1] ? -w_vl : w_vl;
    assign w_dr  = {w_ar, 16'b0} >> FRAC_BITS;
    assign w_dl  = {w_al, 16'b0} >> FRAC_BITS;
    assign w_se  = 32'(r_steer);
    assign w_te  = 32'(r_thr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left  <= i_left_cm;
            r_front <= i_front_cm;
            r_right <= i_right_cm;
            r_vb    <= i_valid_bits;
            r_ms    <= (i_elapsed_ms == '0) ? MS_W'(10) : i_elapsed_ms;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MUL_KP_E:   r_p1  <= MA'(m_p);
                MUL_P1_MS:  r_t1  <= m_p;
                MUL_KD_DE:  r_p2  <= MA'(m_p);
                MUL_P2_K:   r_t2  <= m_p;
                MUL_SQ_NUM: r_sqn <= DVW'(m_p);
                MUL_SQ_DEN: r_sqd <= DVW'(m_p);
                default: ;
            endcase
        end
        if (i_cmd.pd_sum) begin
            r_num <= ms_gt1 ? (NW'(r_t1) + NW'(r_t2)) : NW'(r_p1);
        end
        if (i_cmd.div_load_pd) begin
            r_pd_neg <= r_num[NW-1];
            r_pd_sat <= w_mag >= NW'(w_dlim);
            r_rem    <= RW'(w_mag);
            r_dvs    <= w_dlim;
            r_quo    <= '0;
        end
        if (i_cmd.div_load_th) begin
            r_rem <= RW'(r_sqn);
            r_dvs <= r_sqd;
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? (w_sh - RW'(r_dvs)) : w_sh;
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
        if (i_cmd.pd_save) begin
            r_sref <= sv ? (w_pdv + w_bias) : '0;
        end
        if (i_cmd.emit) begin
            r_o_rduty <= (w_dr > AW'(DUTY_CAP)) ? DUTY_CAP : w_dr[DUTY_W-1:0];
            r_o_lduty <= (w_dl > AW'(DUTY_CAP)) ? DUTY_CAP : w_dl[DUTY_W-1:0];
            r_o_sw    <= w_sw;
            r_o_rdir  <= w_sw ? w_sr : SIGN_ZERO;
            r_o_ldir  <= w_sw ? w_sl : SIGN_ZERO;
            r_o_steer <= w_se[LVL_W-1:0];
            r_o_thr   <= w_te[LVL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer <= '0;
            r_thr   <= '0;
            r_prev  <= '0;
            r_rsign <= SIGN_ZERO;
            r_lsign <= SIGN_ZERO;
        end else begin
            if (i_cmd.pd_save && sv) r_prev <= w_e;
            if (i_cmd.update) begin
                r_steer <= n_steer;
                r_thr   <= n_thr;
            end
            if (i_cmd.emit && w_sw) begin
                r_rsign <= w_sr;
                r_lsign <= w_sl;
            end
        end
    end

    assign o_right_duty     = r_o_rduty;
    assign o_left_duty      = r_o_lduty;
    assign o_dir_switch     = r_o_sw;
    assign o_right_dir      = r_o_rdir;
    assign o_left_dir       = r_o_ldir;
    assign o_steer_level    = r_o_steer;
    assign o_throttle_level = r_o_thr;
endmodule

[tb/wall_follow_drive_controller_core_test.sv]
`timescale 1ns / 1ps
module wall_follow_drive_controller_core_test;
    import wfdc_pkg::*;

    localparam int ONE_Q      = 1 << 14;
    localparam int DEADBAND   = 819;     // 0.05
    localparam int STEER_SLEW = 1966;    // 0.12
    localparam int THR_SLEW   = 983;     // 0.06
    localparam int WALL_BIAS  = 13107;   // 0.8
    localparam int THR_CAP    = 5734;    // 0.35
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [15:0] right_duty;
        logic [15:0] left_duty;
        logic        dir_switch;
        t_sign       right_dir;
        t_sign       left_dir;
        logic [15:0] steer_level;
        logic [15:0] throttle_level;
    } t_wheel_cmd;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    wfdc_in_if #(.DIST_BITS(10)) in_ch();
    wfdc_out_if out_ch();

    wall_follow_drive_controller_core uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // controller registers and state as the block should hold them
    logic        track_right;
    logic [15:0] kp, kd;
    logic [9:0]  wall_goal, wall_near, front_stop, front_slow, estop;
    int          steer_st, throttle_st, prev_err;
    t_sign       right_sign_q, left_sign_q;

    t_wheel_cmd  cmd_q[$];
    int          error_count;
    int          cycle_count;
    int          sink_stall;
    bit          quiet;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic int clip(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_sign sign_of(int v);
        return v > 0 ? SIGN_POS : (v < 0 ? SIGN_NEG : SIGN_ZERO);
    endfunction

    function automatic logic [15:0] duty_of(int v);
        int a;
        a = (v < 0 ? -v : v) * 4;
        return a > int'(DUTY_CAP) ? DUTY_CAP : a[15:0];
    endfunction

    task automatic predict_tick(input logic [9:0] lcm, input logic [9:0] fcm,
                                input logic [9:0] rcm, input logic [2:0] vb,
                                input logic [15:0] ms_raw);
        longint unsigned ms, nu, du, mag, q, r, tot;
        longint num;
        int tref, sref, e, pd, t, s, vr, vl;
        bit sv;
        int unsigned scm;
        t_sign sr, sl;
        t_wheel_cmd c;
        ms = (ms_raw == 0) ? 10 : ms_raw;
        if (!vb[1] || fcm <= estop || fcm <= front_stop) tref = 0;
        else if (fcm >= front_slow) tref = ONE_Q;
        else begin
            nu = fcm - front_stop;
            du = front_slow - front_stop;
            tref = int'(((nu * nu) << 14) / (du * du));
        end
        sref = 0;
        sv = track_right ? vb[2] : vb[0];
        scm = track_right ? rcm : lcm;
        if (sv) begin
            e = int'(scm) - int'(wall_goal);
            if (ms > 1) begin
                num = longint'(kp) * e * longint'(ms) + longint'(kd) * (e - prev_err) * 1000;
                du = ms;
            end else begin
                num = longint'(kp) * e;
                du = 1;
            end
            mag = num < 0 ? -num : num;
            if (mag >= (du << 16)) pd = ONE_Q;
            else begin
                q = mag / du;
                r = mag % du;
                tot = (q << 14) + ((r << 14) / du);
                pd = int'(tot >> 16);
            end
            if (num < 0) pd = -pd;
            pd = clip(pd, -ONE_Q, ONE_Q);
            prev_err = e;
            sref = track_right ? -pd : pd;
            if (scm > 0 && scm < wall_near) begin
                sref += track_right ? -WALL_BIAS : WALL_BIAS;
                if (tref > THR_CAP) tref = THR_CAP;
            end
        end
        steer_st += clip(sref - steer_st, -STEER_SLEW, STEER_SLEW);
        throttle_st += clip(tref - throttle_st, -THR_SLEW, THR_SLEW);
        t = clip(throttle_st, -ONE_Q, ONE_Q);
        s = clip(steer_st, -ONE_Q, ONE_Q);
        vr = clip(t + s, -ONE_Q, ONE_Q);
        vl = clip(t - s, -ONE_Q, ONE_Q);
        if (vr > -DEADBAND && vr < DEADBAND) vr = 0;
        if (vl > -DEADBAND && vl < DEADBAND) vl = 0;
        sr = sign_of(vr);
        sl = sign_of(vl);
        c.dir_switch = 1'b0;
        c.right_dir = SIGN_ZERO;
        c.left_dir = SIGN_ZERO;
        if (sr != right_sign_q || sl != left_sign_q) begin
            c.dir_switch = 1'b1;
            c.right_dir = sr;
            c.left_dir = sl;
            right_sign_q = sr;
            left_sign_q = sl;
        end
        c.right_duty = duty_of(vr);
        c.left_duty = duty_of(vl);
        c.steer_level = steer_st[15:0];
        c.throttle_level = throttle_st[15:0];
        cmd_q.push_back(c);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", field, got, want,
                 cycle_count);
    endtask

    // output side: random stall per item, zero in quiet stretches
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            out_ch.ready = 1'b0;
            sink_stall--;
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_wheel_cmd w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (cmd_q.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                w = cmd_q.pop_front();
                if (out_ch.right_duty !== w.right_duty)
                    report_mismatch("right_duty", out_ch.right_duty, w.right_duty);
                if (out_ch.left_duty !== w.left_duty)
                    report_mismatch("left_duty", out_ch.left_duty, w.left_duty);
                if (out_ch.dir_switch !== w.dir_switch)
                    report_mismatch("dir_switch", out_ch.dir_switch, w.dir_switch);
                if (out_ch.right_dir !== w.right_dir)
                    report_mismatch("right_dir", out_ch.right_dir, w.right_dir);
                if (out_ch.left_dir !== w.left_dir)
                    report_mismatch("left_dir", out_ch.left_dir, w.left_dir);
                if (out_ch.steer_level !== w.steer_level)
                    report_mismatch("steer_level", $signed(out_ch.steer_level),
                                    $signed(w.steer_level));
                if (out_ch.throttle_level !== w.throttle_level)
                    report_mismatch("throttle_level", $signed(out_ch.throttle_level),
                                    $signed(w.throttle_level));
            end
            sink_stall = quiet ? 0 : $urandom_range(0, 8);
        end
    end

    task automatic send_tick(input logic [9:0] lcm, input logic [9:0] fcm,
                             input logic [9:0] rcm, input logic [2:0] vb,
                             input logic [15:0] ms);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.left_cm = lcm;
        in_ch.front_cm = fcm;
        in_ch.right_cm = rcm;
        in_ch.valid_bits = vb;
        in_ch.elapsed_ms = ms;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_tick(lcm, fcm, rcm, vb, ms);
        @(negedge i_clk);
    endtask

    task automatic drain;
        in_ch.valid = 1'b0;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // only called while the controller is idle
    task automatic set_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_TRACK_RIGHT:  track_right = val[0];
            CFG_KP_GAIN:      kp = val;
            CFG_KD_GAIN:      kd = val;
            CFG_WALL_GOAL:    wall_goal = val[9:0];
            CFG_WALL_NEAR:    wall_near = val[9:0];
            CFG_FRONT_STOP:   front_stop = val[9:0];
            CFG_FRONT_SLOW:   front_slow = val[9:0];
            CFG_ESTOP:        estop = val[9:0];
            default: ;
        endcase
    endtask

    task automatic test_default_setting;
        send_tick(0, 0, 0, 3'b000, 0);
        send_tick(0, 1023, 10, 3'b111, 10);
        send_tick(0, 1023, 30, 3'b111, 0);      // elapsed zero
        send_tick(0, 1023, 40, 3'b111, 1);      // derivative dropped
        send_tick(0, 5, 40, 3'b111, 12);        // e-stop
        send_tick(0, 50, 0, 3'b111, 15);        // zero side reading
        send_tick(0, 60, 15, 3'b111, 15);       // too close
        send_tick(0, 70, 1023, 3'b111, 2);      // PD saturates
        send_tick(1023, 90, 1023, 3'b011, 20);  // followed side invalid
        send_tick(1023, 1023, 8, 3'b101, 65535);
        send_tick(512, 40, 10, 3'b111, 16'h8000);
    endtask

    task automatic test_left_wall;
        drain();
        set_reg(CFG_TRACK_RIGHT, 16'd0);
        set_reg(CFG_KP_GAIN, 16'd9000);
        set_reg(CFG_KD_GAIN, 16'd2000);
        set_reg(CFG_WALL_GOAL, 16'd30);
        set_reg(CFG_WALL_NEAR, 16'd12);
        send_tick(5, 200, 0, 3'b111, 10);
        send_tick(45, 200, 0, 3'b011, 18);
        send_tick(1023, 200, 0, 3'b011, 3);
        send_tick(20, 200, 700, 3'b110, 10);
    endtask

    task automatic test_stop_not_below_slow;
        drain();
        set_reg(CFG_FRONT_STOP, 16'd100);
        set_reg(CFG_FRONT_SLOW, 16'd100);
        set_reg(CFG_ESTOP, 16'd0);
        send_tick(30, 100, 30, 3'b111, 10);
        send_tick(30, 101, 30, 3'b111, 10);
        drain();
        set_reg(CFG_FRONT_STOP, 16'd1022);
        set_reg(CFG_FRONT_SLOW, 16'd1);
        send_tick(30, 1022, 30, 3'b111, 10);
        send_tick(30, 1023, 30, 3'b111, 10);
    endtask

    task automatic test_register_extremes;
        drain();
        set_reg(CFG_TRACK_RIGHT, 16'd1);
        set_reg(CFG_KP_GAIN, 16'hFFFF);
        set_reg(CFG_KD_GAIN, 16'hFFFF);
        set_reg(CFG_WALL_GOAL, 16'd1023);
        set_reg(CFG_WALL_NEAR, 16'd1023);
        set_reg(CFG_FRONT_STOP, 16'd0);
        set_reg(CFG_FRONT_SLOW, 16'd1023);
        set_reg(CFG_ESTOP, 16'd1023);
        send_tick(0, 1023, 1, 3'b111, 65535);
        send_tick(0, 1022, 1022, 3'b111, 1);
        drain();
        set_reg(CFG_KP_GAIN, 16'd0);
        set_reg(CFG_KD_GAIN, 16'd0);
        set_reg(CFG_WALL_GOAL, 16'd0);
        set_reg(CFG_WALL_NEAR, 16'd0);
        set_reg(CFG_ESTOP, 16'd0);
        send_tick(1023, 1, 1023, 3'b111, 7);
        send_tick(1023, 512, 0, 3'b111, 0);
    endtask

    task automatic random_setting;
        drain();
        set_reg(CFG_TRACK_RIGHT, 16'($urandom_range(0, 1)));
        set_reg(CFG_KP_GAIN, 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                           : $urandom_range(500, 8000)));
        set_reg(CFG_KD_GAIN, 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                           : $urandom_range(500, 12000)));
        set_reg(CFG_WALL_GOAL, 16'($urandom_range(5, 40)));
        set_reg(CFG_WALL_NEAR, 16'($urandom_range(0, 60)));
        set_reg(CFG_FRONT_STOP, 16'($urandom_range(10, 40)));
        set_reg(CFG_FRONT_SLOW, 16'($urandom_range(0, 5) == 0 ? $urandom_range(1, 40)
                                                              : $urandom_range(41, 150)));
        set_reg(CFG_ESTOP, 16'($urandom_range(0, 15)));
    endtask

    // mostly plausible readings of a robot near a wall, some raw noise
    task automatic test_random_drive(input int n, input bit hold_off);
        logic [9:0] l, f, r;
        logic [2:0] vb;
        logic [15:0] ms;
        for (int i = 0; i < n; i++) begin
            if (hold_off && i % 25 == 24) drain();
            if (i == n / 2) quiet = 1'b1;
            if (i == n / 2 + 20) quiet = 1'b0;
            if ($urandom_range(0, 4) == 0) begin
                l = 10'($urandom_range(0, 1023));
                f = 10'($urandom_range(0, 1023));
                r = 10'($urandom_range(0, 1023));
                vb = 3'($urandom_range(0, 7));
                ms = 16'($urandom_range(0, 65535));
            end else begin
                l = 10'($urandom_range(0, 80));
                f = 10'($urandom_range(0, 200));
                r = 10'($urandom_range(0, 80));
                vb = 3'($urandom_range(0, 5) == 0 ? $urandom_range(0, 7) : 7);
                ms = 16'($urandom_range(0, 7) == 0 ? $urandom_range(0, 2)
                                                   : $urandom_range(10, 20));
            end
            send_tick(l, f, r, vb, ms);
        end
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        sink_stall = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TRACK_RIGHT;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.left_cm = '0;
        in_ch.front_cm = '0;
        in_ch.right_cm = '0;
        in_ch.valid_bits = '0;
        in_ch.elapsed_ms = '0;
        out_ch.ready = 1'b0;
        track_right = 1'b1;
        kp = KP_RST;
        kd = KD_RST;
        wall_goal = 10'(WALL_GOAL_RST);
        wall_near = 10'(WALL_NEAR_RST);
        front_stop = 10'(FRONT_STOP_RST);
        front_slow = 10'(FRONT_SLOW_RST);
        estop = 10'(ESTOP_RST);
        steer_st = 0;
        throttle_st = 0;
        prev_err = 0;
        right_sign_q = SIGN_ZERO;
        left_sign_q = SIGN_ZERO;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_setting();
        test_left_wall();
        test_stop_not_below_slow();
        test_register_extremes();
        for (int p = 0; p < 4; p++) begin
            random_setting();
            test_random_drive(100, p == 1);
        end

        drain();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/wfdc_pkg.sv
src/wfdc_if.sv
src/wfdc_ctrl.sv
src/wfdc_datapath.sv
src/wall_follow_drive_controller_core.sv
tb/wall_follow_drive_controller_core_test.sv
